@@ design/dds_step_direction_generator_core_macros.svh @@
// Assertion macros shared by the step generator RTL.
// Each macro uses the clk and arst_n signals of the module that includes it.
`ifndef DDS_STEP_DIRECTION_GENERATOR_CORE_MACROS_SVH
`define DDS_STEP_DIRECTION_GENERATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/dsg_pkg.sv @@
// Package for the DDS step and direction generator.
// Holds widths, packing constants and the reset value of the scale register.
// No dependencies.
package dsg_pkg;

	localparam int FRAC_BITS = 22;

	localparam int FREQ_W = 32;
	localparam int SCALE_W = 32;
	localparam int POS_W = 64;
	localparam int PROD_W = FREQ_W + SCALE_W;
	localparam int INC_SHIFT = 24;
	localparam int INC_MAG_W = PROD_W - INC_SHIFT;

	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 72;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(5497558);

	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_CMD = 1'b1;

endpackage

@@ design/dds_step_direction_generator_core.sv @@
// Top level of the DDS step and direction generator for one stepper channel.
// Depends on dsg_pkg and on dds_step_direction_generator_core_macros.svh.
//
// Channel   Direction  Contents
// s_axis    in         tuser: mode; tdata: enable, frequency
// m_axis    out        tdata: step_level, direction_level, position_feedback
// cfg       in         increment_scale, written when cfg_wr_en is high
//
// Each transaction passes through the input register and then the result register.
// A new transaction is taken every cycle while the output is not stalled.
// The rate is set by the 64-bit accumulator add and the 32 by 32 multiply of a command,
// both done in the single stage between the two registers.
// Reset clears all channel state and sets the scale register to its default.
// A stall on the output holds both registers, and the input then stalls.
`include "dds_step_direction_generator_core_macros.svh"

module dds_step_direction_generator_core
	import dsg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// Bit 0: enable; bits 32:1: frequency; bits 39:33: zero.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// Bit 0: mode.
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// Bit 0: step_level; bit 1: direction_level; bits 65:2: position_feedback;
	// bits 71:66: zero.
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_wr_en,
	input  logic [SCALE_W-1:0]    cfg_wr_data
);

	logic                 valid_s1;
	logic                 mode_s1;
	logic                 enable_s1;
	logic [FREQ_W-1:0]    freq_s1;

	logic [SCALE_W-1:0]   scale_q;
	logic [POS_W-1:0]     acc_q;
	logic [INC_MAG_W-1:0] inc_mag_q;
	logic                 inc_neg_q;
	logic [FREQ_W-1:0]    last_freq_q;
	logic                 forward_q;
	logic                 flip_pending_q;
	logic                 step_out_q;

	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic                 advance;
	logic                 freq_neg;
	logic [FREQ_W-1:0]    freq_mag;
	logic [PROD_W-1:0]    product;
	logic [INC_MAG_W-1:0] new_mag;
	logic                 new_fwd;
	logic [POS_W-1:0]     acc_sum;

	logic [POS_W-1:0]     acc_d;
	logic [INC_MAG_W-1:0] inc_mag_d;
	logic                 inc_neg_d;
	logic [FREQ_W-1:0]    last_freq_d;
	logic                 forward_d;
	logic                 flip_pending_d;
	logic                 step_out_d;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1 <= s_axis_tuser;
			enable_s1 <= s_axis_tdata[0];
			freq_s1 <= s_axis_tdata[FREQ_W:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	assign freq_neg = freq_s1[FREQ_W-1];
	assign freq_mag = freq_neg ? (~freq_s1 + FREQ_W'(1)) : freq_s1;
	assign product = PROD_W'(freq_mag) * PROD_W'(scale_q);
	assign new_mag = product[PROD_W-1:INC_SHIFT];
	assign new_fwd = !freq_neg && (new_mag != '0);
	assign acc_sum = inc_neg_q ? (acc_q - POS_W'(inc_mag_q)) : (acc_q + POS_W'(inc_mag_q));

	always_comb begin
		acc_d = acc_q;
		inc_mag_d = inc_mag_q;
		inc_neg_d = inc_neg_q;
		last_freq_d = last_freq_q;
		forward_d = forward_q;
		flip_pending_d = flip_pending_q;
		step_out_d = step_out_q;
		case (mode_s1)
			MODE_TICK: begin
				step_out_d = 1'b0;
				if (flip_pending_q) begin
					flip_pending_d = 1'b0;
				end else if (enable_s1 && (inc_mag_q != '0)) begin
					acc_d = acc_sum;
					step_out_d = acc_q[FRAC_BITS] ^ acc_sum[FRAC_BITS];
				end
			end
			MODE_CMD: begin
				if (enable_s1 && (freq_s1 != last_freq_q)) begin
					last_freq_d = freq_s1;
					inc_mag_d = new_mag;
					inc_neg_d = freq_neg;
					if (new_fwd != forward_q) begin
						forward_d = new_fwd;
						flip_pending_d = 1'b1;
					end
				end
			end
			default: begin
				step_out_d = step_out_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			inc_mag_q <= '0;
			inc_neg_q <= 1'b0;
			last_freq_q <= '0;
			forward_q <= 1'b0;
			flip_pending_q <= 1'b0;
			step_out_q <= 1'b0;
		end else if (advance) begin
			acc_q <= acc_d;
			inc_mag_q <= inc_mag_d;
			inc_neg_q <= inc_neg_d;
			last_freq_q <= last_freq_d;
			forward_q <= forward_d;
			flip_pending_q <= flip_pending_d;
			step_out_q <= step_out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {(OUT_DATA_W - POS_W - 2)'(0), acc_d, forward_d, step_out_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	`DSG_ASSERT_SAME(a_dir_matches_inc, 1'b1,
		forward_q == (!inc_neg_q && (inc_mag_q != '0)),
		"Direction does not match the sign of the stored increment.")
	`DSG_ASSERT_NEXT(a_settle_clears_flag,
		advance && (mode_s1 == MODE_TICK) && flip_pending_q,
		!flip_pending_q && !step_out_q,
		"Settling tick did not clear the pending flip.")
	`DSG_ASSERT_NEXT(a_cmd_keeps_step, advance && (mode_s1 == MODE_CMD),
		(step_out_q == $past(step_out_q)) && (acc_q == $past(acc_q)),
		"A command changed the step pin or the position.")
	`DSG_ASSERT_SAME(a_flip_on_dir_change, $rose(flip_pending_q),
		forward_q != $past(forward_q),
		"Pending flip raised without a direction change.")

endmodule

@@ tb/dds_step_direction_generator_core_tb.sv @@
// Self-checking testbench for the DDS step and direction generator core.
// Drives stream transactions with random idling and checks every result against
// an in-bench model of the channel; depends on dsg_pkg and the core RTL.
module dds_step_direction_generator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dsg_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             direction;
		logic             step;
	} pins_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_wr_en;
	logic [SCALE_W-1:0]    cfg_wr_data;

	logic [SCALE_W-1:0] chan_scale;
	logic [POS_W-1:0]   chan_acc;
	logic [POS_W-1:0]   chan_inc;
	logic [FREQ_W-1:0]  chan_last_freq;
	logic               chan_fwd;
	logic               chan_flip;
	logic               chan_step;

	pins_t expected_pins[$];

	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int hold_request = 0;
	int mismatches = 0;
	int items_sent = 0;
	int cmds_sent = 0;
	int steps_seen = 0;
	int flips_seen = 0;
	int scale_writes = 0;

	always #5 clk = ~clk;

	dds_step_direction_generator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	function automatic logic [POS_W-1:0] scaled_increment(input logic [FREQ_W-1:0] freq,
			input logic [SCALE_W-1:0] scale);
		logic [POS_W-1:0] mag;
		logic [POS_W-1:0] quot;
		mag = freq[FREQ_W-1] ? {32'b0, -freq} : {32'b0, freq};
		quot = (mag * {32'b0, scale}) >> INC_SHIFT;
		return freq[FREQ_W-1] ? -quot : quot;
	endfunction

	task automatic advance_channel(input logic mode, input logic en, input logic [FREQ_W-1:0] freq);
		logic [POS_W-1:0] prev;
		logic new_fwd;
		if (mode == MODE_TICK) begin
			chan_step = 1'b0;
			if (chan_flip) begin
				chan_flip = 1'b0;
			end else if (en && chan_inc != '0) begin
				prev = chan_acc;
				chan_acc = prev + chan_inc;
				if (prev[FRAC_BITS] != chan_acc[FRAC_BITS]) begin
					chan_step = 1'b1;
					steps_seen++;
				end
			end
		end else if (en && freq != chan_last_freq) begin
			chan_last_freq = freq;
			chan_inc = scaled_increment(freq, chan_scale);
			new_fwd = !chan_inc[POS_W-1] && chan_inc != '0;
			if (new_fwd != chan_fwd) begin
				chan_fwd = new_fwd;
				chan_flip = 1'b1;
				flips_seen++;
			end
		end
		expected_pins.push_back(pins_t'{chan_acc, chan_fwd, chan_step});
	endtask

	task automatic send_item(input logic mode, input logic en, input logic [FREQ_W-1:0] freq);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {{(IN_DATA_W-FREQ_W-1){1'b0}}, freq, en};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		advance_channel(mode, en, freq);
		items_sent++;
		if (mode == MODE_CMD) cmds_sent++;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_pins.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_scale(input logic [SCALE_W-1:0] value);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		chan_scale = value;
		scale_writes++;
	endtask

	function automatic logic [FREQ_W-1:0] random_frequency();
		logic [FREQ_W-1:0] mag;
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 2048) - 1024;
			2: begin
				mag = $urandom_range(1 << 20, 1 << 27);
				return $urandom_range(0, 1) ? -mag : mag;
			end
			default: return $urandom_range(0, 1) ? chan_last_freq : -chan_last_freq;
		endcase
	endfunction

	// Mostly a command followed by a run of ticks, with some stray transactions mixed in.
	task automatic run_motion(input int count);
		int sent;
		int run_len;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
				sent++;
			end else begin
				send_item(MODE_CMD, $urandom_range(0, 9) != 0, random_frequency());
				run_len = $urandom_range(1, 24);
				repeat (run_len) send_item(MODE_TICK, $urandom_range(0, 15) != 0, $urandom());
				sent += run_len + 1;
			end
		end
	endtask

	task automatic test_directed_cases();
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_CMD, 1'b1, 32'h0000_0000);
		send_item(MODE_CMD, 1'b1, 32'h0000_0001);
		send_item(MODE_CMD, 1'b0, 32'h0100_0000);
		send_item(MODE_CMD, 1'b1, 32'h0100_0000);
		send_item(MODE_TICK, 1'b1, 32'hFFFF_FFFF);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_TICK, 1'b0, 32'h0000_0000);
		send_item(MODE_CMD, 1'b1, 32'h0100_0000);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_CMD, 1'b1, 32'hFF00_0000);
		send_item(MODE_TICK, 1'b0, 32'h0000_0000);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_CMD, 1'b1, 32'h8000_0000);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_CMD, 1'b1, 32'h7FFF_FFFF);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		repeat (3) send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_CMD, 1'b1, 32'hFFFF_FFFF);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
		send_item(MODE_TICK, 1'b1, 32'h0000_0000);
	endtask

	task automatic test_scale_extremes();
		logic [SCALE_W-1:0] settings[6];
		settings = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
			$urandom(), SCALE_RESET};
		foreach (settings[i]) begin
			write_scale(settings[i]);
			send_item(MODE_CMD, 1'b1, 32'h7FFF_FFFF);
			send_item(MODE_CMD, 1'b1, 32'h8000_0000);
			run_motion(120);
		end
	endtask

	task automatic test_random_traffic();
		run_motion(600);
	endtask

	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		hold_request = 80;
		send_item(MODE_CMD, 1'b1, random_frequency());
		repeat (39) send_item(MODE_TICK, 1'b1, $urandom());
		wait_idle();
		gaps_on = 1'b1;
	endtask

	task automatic test_steady_stream();
		wait_idle();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		run_motion(200);
	endtask

	task automatic note_mismatch(input string field, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		mismatches++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field,
			$signed(want), $signed(got));
	endtask

	initial begin : receiver
		int hold_len;
		forever begin
			if (hold_request != 0) begin
				hold_len = hold_request;
				hold_request = 0;
				m_axis_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_results
		pins_t want;
		pins_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = pins_t'(m_axis_tdata[POS_W+1:0]);
			if (expected_pins.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transaction, expected none, actual %h",
					$realtime, m_axis_tdata);
			end else begin
				want = expected_pins.pop_front();
				if (got.step !== want.step)
					note_mismatch("step_level", POS_W'(want.step), POS_W'(got.step));
				if (got.direction !== want.direction)
					note_mismatch("direction_level", POS_W'(want.direction),
						POS_W'(got.direction));
				if (got.position !== want.position)
					note_mismatch("position_feedback", want.position, got.position);
			end
		end
	end

	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= MODE_TICK;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		chan_scale = SCALE_RESET;
		chan_acc = '0;
		chan_inc = '0;
		chan_last_freq = '0;
		chan_fwd = 1'b0;
		chan_flip = 1'b0;
		chan_step = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_scale_extremes();
		test_random_traffic();
		test_output_backpressure();
		test_steady_stream();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Sent %0d transactions (%0d frequency commands) over %0d scale settings.",
			items_sent, cmds_sent, scale_writes);
		$display("Saw %0d step pulses and %0d direction changes; %0d mismatches.",
			steps_seen, flips_seen, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
